>>> hdl/y86fd_pkg.sv
// shared types and constants for the y86-64 fetch and decode block
package y86fd_pkg;

	localparam int PC_W    = 12;
	localparam int NPC_W   = 13;
	localparam int IN_W    = 96;
	localparam int OUT_W   = 104;

	localparam logic [3:0] CL_HALT    = 4'd0;
	localparam logic [3:0] CL_NOP     = 4'd1;
	localparam logic [3:0] CL_CMOV    = 4'd2;
	localparam logic [3:0] CL_IRMOVQ  = 4'd3;
	localparam logic [3:0] CL_RMMOVQ  = 4'd4;
	localparam logic [3:0] CL_MRMOVQ  = 4'd5;
	localparam logic [3:0] CL_OPQ     = 4'd6;
	localparam logic [3:0] CL_JUMP    = 4'd7;
	localparam logic [3:0] CL_CALL    = 4'd8;
	localparam logic [3:0] CL_RET     = 4'd9;
	localparam logic [3:0] CL_PUSHQ   = 4'd10;
	localparam logic [3:0] CL_POPQ    = 4'd11;
	localparam logic [3:0] CL_IOTRAP  = 4'd12;
	localparam logic [3:0] CL_INVALID = 4'd13;

	localparam logic [3:0] OP_HALT   = 4'h0;
	localparam logic [3:0] OP_NOP    = 4'h1;
	localparam logic [3:0] OP_CMOV   = 4'h2;
	localparam logic [3:0] OP_IRMOVQ = 4'h3;
	localparam logic [3:0] OP_RMMOVQ = 4'h4;
	localparam logic [3:0] OP_MRMOVQ = 4'h5;
	localparam logic [3:0] OP_OPQ    = 4'h6;
	localparam logic [3:0] OP_JUMP   = 4'h7;
	localparam logic [3:0] OP_CALL   = 4'h8;
	localparam logic [3:0] OP_RET    = 4'h9;
	localparam logic [3:0] OP_PUSHQ  = 4'hA;
	localparam logic [3:0] OP_POPQ   = 4'hB;
	localparam logic [3:0] OP_IOTRAP = 4'hC;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_HLT = 2'd1;
	localparam logic [1:0] ST_ADR = 2'd2;
	localparam logic [1:0] ST_INS = 2'd3;

	localparam logic [3:0] NO_REG = 4'hF;

	typedef struct packed {
		logic [3:0]       pad;
		logic [15:0]      window_hi;
		logic [63:0]      window_lo;
		logic [PC_W-1:0]  fetch_pc;
	} fetch_item_t;

	typedef struct packed {
		logic [4:0]       pad;
		logic [1:0]       status;
		logic [NPC_W-1:0] next_pc;
		logic [3:0]       inst_length;
		logic [63:0]      const_value;
		logic [3:0]       reg_b;
		logic [3:0]       reg_a;
		logic [3:0]       func_code;
		logic [3:0]       inst_class;
	} decode_result_t;

endpackage

>>> hdl/y86fd_stage.sv
// valid/ready register stage holding one transaction
module y86fd_stage #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             valid_q;
	logic [WIDTH-1:0] data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_q <= in_data;
		end
	end

endmodule

>>> hdl/y86fd_decode.sv
// combinational decode of one instruction window
module y86fd_decode import y86fd_pkg::*; #(
	parameter int MEM_SIZE  = 4096,
	parameter int REG_COUNT = 15
) (
	input  fetch_item_t    item,
	output decode_result_t result
);

	localparam int LW = ($clog2(MEM_SIZE + 1) > NPC_W) ? $clog2(MEM_SIZE + 1) : NPC_W;
	localparam logic [LW-1:0] MEM_LIM   = LW'(MEM_SIZE);
	localparam logic [4:0]    REG_LIM   = 5'(REG_COUNT);

	logic [3:0]    hn;
	logic [3:0]    fn;
	logic [3:0]    ra;
	logic [3:0]    rb;
	logic          ra_ok;
	logic          rb_ok;
	logic [3:0]    cls;
	logic [3:0]    len;
	logic [1:0]    st;
	logic          has_regs;
	logic          regs_good;
	logic [LW-1:0] pc_ext;
	logic [LW-1:0] end_pc;
	logic [63:0]   cval;

	assign hn     = item.window_lo[7:4];
	assign fn     = item.window_lo[3:0];
	assign ra     = item.window_lo[15:12];
	assign rb     = item.window_lo[11:8];
	assign ra_ok  = {1'b0, ra} < REG_LIM;
	assign rb_ok  = {1'b0, rb} < REG_LIM;
	assign pc_ext = LW'(item.fetch_pc);
	assign end_pc = pc_ext + LW'(len);

	always_comb begin
		cls       = CL_INVALID;
		len       = 4'd1;
		st        = ST_OK;
		has_regs  = 1'b0;
		regs_good = 1'b1;
		case (hn)
			OP_HALT: begin
				cls = (fn == 4'd0) ? CL_HALT : CL_INVALID;
				st  = ST_HLT;
			end
			OP_NOP: begin
				cls = (fn == 4'd0) ? CL_NOP : CL_INVALID;
			end
			OP_CMOV: begin
				cls       = (fn inside {[4'd0:4'd6]}) ? CL_CMOV : CL_INVALID;
				len       = 4'd2;
				has_regs  = 1'b1;
				regs_good = ra_ok && rb_ok;
			end
			OP_IRMOVQ: begin
				cls       = (fn == 4'd0) ? CL_IRMOVQ : CL_INVALID;
				len       = 4'd10;
				has_regs  = 1'b1;
				regs_good = (ra == NO_REG) && rb_ok;
			end
			OP_RMMOVQ, OP_MRMOVQ: begin
				cls       = (fn == 4'd0) ? hn : CL_INVALID;
				len       = 4'd10;
				has_regs  = 1'b1;
				regs_good = ra_ok && (rb_ok || rb == NO_REG);
			end
			OP_OPQ: begin
				cls       = (fn inside {[4'd0:4'd3]}) ? CL_OPQ : CL_INVALID;
				len       = 4'd2;
				has_regs  = 1'b1;
				regs_good = ra_ok && rb_ok;
			end
			OP_JUMP: begin
				cls = (fn inside {[4'd0:4'd6]}) ? CL_JUMP : CL_INVALID;
				len = 4'd9;
			end
			OP_CALL: begin
				cls = (fn == 4'd0) ? CL_CALL : CL_INVALID;
				len = 4'd9;
			end
			OP_RET: begin
				cls = (fn == 4'd0) ? CL_RET : CL_INVALID;
			end
			OP_PUSHQ, OP_POPQ: begin
				cls       = (fn == 4'd0) ? hn : CL_INVALID;
				len       = 4'd2;
				has_regs  = 1'b1;
				regs_good = ra_ok && (rb == NO_REG);
			end
			OP_IOTRAP: begin
				cls = (fn inside {[4'd0:4'd5]}) ? CL_IOTRAP : CL_INVALID;
			end
			default: begin
				cls = CL_INVALID;
			end
		endcase
	end

	always_comb begin
		case (cls)
			CL_JUMP, CL_CALL: cval = {item.window_hi[7:0], item.window_lo[63:8]};
			CL_IRMOVQ, CL_RMMOVQ, CL_MRMOVQ: cval = {item.window_hi, item.window_lo[63:16]};
			default: cval = 64'd0;
		endcase
	end

	always_comb begin
		result             = '0;
		result.inst_class  = CL_INVALID;
		result.reg_a       = NO_REG;
		result.reg_b       = NO_REG;
		result.inst_length = 4'd1;
		result.next_pc     = NPC_W'(pc_ext + LW'(1));
		if (pc_ext >= MEM_LIM) begin
			result.status = ST_ADR;
		end else if (cls == CL_INVALID) begin
			result.status = ST_INS;
		end else if (end_pc > MEM_LIM) begin
			result.status      = ST_ADR;
			result.inst_length = len;
			result.next_pc     = end_pc[NPC_W-1:0];
		end else if (!regs_good) begin
			result.status      = ST_INS;
			result.inst_length = len;
			result.next_pc     = end_pc[NPC_W-1:0];
		end else begin
			result.inst_class  = cls;
			result.func_code   = fn;
			result.reg_a       = has_regs ? ra : NO_REG;
			result.reg_b       = has_regs ? rb : NO_REG;
			result.const_value = cval;
			result.inst_length = len;
			result.next_pc     = end_pc[NPC_W-1:0];
			result.status      = st;
		end
	end

endmodule

>>> hdl/y86_instruction_fetch_decode_top.sv
// top level of the y86-64 instruction fetch and decode block
// the input stage registers each transaction, the decode is combinational, and the result stage registers the result
// throughput: one transaction per cycle while the master side is ready, set by the input and result register stages
// a stalled master side holds the result and back-pressures only once both stages are full
// reset: arst_n clears both stage valid flags asynchronously, payload is not reset
module y86_instruction_fetch_decode_top import y86fd_pkg::*; #(
	parameter int MEM_SIZE  = 4096,
	parameter int REG_COUNT = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// fetch_pc, window_lo, window_hi, zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// inst_class, func_code, reg_a, reg_b, const_value, inst_length, next_pc, status, zero pad
	output logic [OUT_W-1:0] m_axis_tdata
);

	logic           valid_s1;
	logic           ready_s1;
	fetch_item_t    item_s1;
	decode_result_t result_d;
	decode_result_t result_s2;

	y86fd_stage #(.WIDTH(IN_W)) u_stage_s1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (valid_s1),
		.out_ready (ready_s1),
		.out_data  (item_s1)
	);

	y86fd_decode #(.MEM_SIZE(MEM_SIZE), .REG_COUNT(REG_COUNT)) u_decode (
		.item   (item_s1),
		.result (result_d)
	);

	y86fd_stage #(.WIDTH(OUT_W)) u_stage_s2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (ready_s1),
		.in_data   (result_d),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result_s2)
	);

	assign m_axis_tdata = result_s2;

endmodule

>>> hdl/y86fd_checker.sv
// port-level checks on the fetch and decode top, attached by bind
module y86fd_checker import y86fd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	decode_result_t res;
	assign res = m_axis_tdata;

	a_reset_clears: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_error_class: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (res.status == ST_ADR || res.status == ST_INS)
		|-> res.inst_class == CL_INVALID && res.const_value == 64'd0)
		else $error("error transaction with decoded fields");

	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.inst_class == CL_HALT |-> res.status == ST_HLT)
		else $error("halt without halt status");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.inst_length == 4'd1 || res.inst_length == 4'd2
		|| res.inst_length == 4'd9 || res.inst_length == 4'd10)
		else $error("bad instruction length");

endmodule

bind y86_instruction_fetch_decode_top y86fd_checker u_checker (.*);
